@@ design/heap_sorter_up_down_core_defines.svh @@
// assertion macros used by the checker file
`ifndef HEAP_SORTER_UP_DOWN_CORE_DEFINES_SVH
`define HEAP_SORTER_UP_DOWN_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HSUD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HSUD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hsud_pkg.sv @@
`default_nettype none

package hsud_pkg;

    // store capacity and derived widths
    localparam int MAX_ITEMS = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CHILD_W   = ADDR_W + 2;

    typedef logic signed [DATA_W-1:0] data_t;

    // true when a belongs nearer the heap root than b
    function automatic logic hsud_outranks(input data_t a, input data_t b,
                                           input logic min_heap);
        hsud_outranks = min_heap ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

@@ design/heap_sorter_up_down_core.sv @@
// channel   | ports                                  | handshake
// ----------+----------------------------------------+------------------------------
// input     | value, final_item                      | start high while busy low
// result    | sorted_value, last_out, overflow       | result_valid, one cycle each
// config    | cfg_wr_data (descending)               | cfg_wr_en, no wait
//
// loading takes one value per cycle; busy stays low between non-final values.
// the final value starts the sort: each sift fetches and loads the moving
// value, then runs child read, left compare, and right compare and write for
// each step, both compares on the shared comparator.
// each output value is read through a registered read port, then presented.
// reset (rst_n, async) empties the set; the receiver cannot stall results.
`default_nettype none

module heap_sorter_up_down_core
    import hsud_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic signed [31:0] value,
    input  wire logic              final_item,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    output logic                   result_valid,
    output logic signed [31:0]     sorted_value,
    output logic                   last_out,
    output logic                   overflow
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_FLOAD = 3'd2;
    localparam logic [2:0] S_SREAD = 3'd3;
    localparam logic [2:0] S_SCMPL = 3'd4;
    localparam logic [2:0] S_SCMPR = 3'd5;
    localparam logic [2:0] S_OREAD = 3'd6;
    localparam logic [2:0] S_OEMIT = 3'd7;

    localparam logic PH_BUILD   = 1'b0;
    localparam logic PH_EXTRACT = 1'b1;

    // control registers
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dropped_reg, dropped_next;
    logic              desc_reg, desc_next;
    logic              phase_reg, phase_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] outk_reg, outk_next;
    logic              bleft_reg, bleft_next;

    // payload registers
    data_t cur_reg, cur_next;
    data_t best_reg, best_next;
    data_t rd_a_reg, rd_b_reg;

    // value store
    data_t             mem [MAX_ITEMS];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, raddr_a, raddr_b;
    data_t             mem_wdata;

    // shared comparator
    data_t cmp_a, cmp_b;
    logic  cmp_win;

    logic              accept, has_room, out_last;
    logic [CNT_W-1:0]  n_load;
    logic [CHILD_W-1:0] lft, rgt;

    assign accept   = start && !busy;
    assign has_room = cnt_reg < CNT_W'(MAX_ITEMS);
    assign n_load   = has_room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign lft      = (CHILD_W'(pos_reg) << 1) + CHILD_W'(1);
    assign rgt      = lft + CHILD_W'(1);
    assign cmp_win  = hsud_outranks(cmp_a, cmp_b, desc_reg);
    assign out_last = (CNT_W'(outk_reg) + CNT_W'(1)) == cnt_reg;

    // result ports
    assign busy         = state_reg != S_IDLE;
    assign result_valid = state_reg == S_OEMIT;
    assign sorted_value = rd_a_reg;
    assign last_out     = result_valid && out_last;
    assign overflow     = dropped_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        desc_next    = cfg_wr_en ? cfg_wr_data : desc_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        outk_next    = outk_reg;
        bleft_next   = bleft_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = cur_reg;
        raddr_a      = pos_reg;
        raddr_b      = pos_reg;
        cmp_a        = rd_a_reg;
        cmp_b        = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // load transaction: store or drop
                    if (has_room)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_reg[ADDR_W-1:0];
                        mem_wdata = value;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    cnt_next = n_load;
                    if (final_item)
                    begin
                        outk_next = '0;
                        if (n_load >= CNT_W'(2))
                        begin
                            phase_next = PH_BUILD;
                            idx_next   = ADDR_W'((n_load >> 1) - CNT_W'(1));
                            pos_next   = ADDR_W'((n_load >> 1) - CNT_W'(1));
                            len_next   = n_load;
                            state_next = S_FETCH;
                        end
                        else if (n_load == CNT_W'(1))
                        begin
                            state_next = S_OREAD;
                        end
                        else
                        begin
                            cnt_next     = '0;
                            dropped_next = 1'b0;
                        end
                    end
                end
            end

            // read the value that starts the sift, and on extract the root as well
            S_FETCH:
            begin
                mem_re = 1'b1;
                if (phase_reg == PH_EXTRACT)
                begin
                    raddr_a = '0;
                    raddr_b = len_reg[ADDR_W-1:0];
                end
                state_next = S_FLOAD;
            end

            // take the moving value; on extract park the root at the heap end
            S_FLOAD:
            begin
                if (phase_reg == PH_EXTRACT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = len_reg[ADDR_W-1:0];
                    mem_wdata = rd_a_reg;
                    cur_next  = rd_b_reg;
                end
                else
                begin
                    cur_next = rd_a_reg;
                end
                state_next = S_SREAD;
            end

            // read both children, or settle at a leaf
            S_SREAD:
            begin
                if (lft >= CHILD_W'(len_reg))
                begin
                    mem_we = 1'b1;
                    state_next = S_FETCH;
                    if (phase_reg == PH_BUILD)
                    begin
                        if (idx_reg == '0)
                        begin
                            phase_next = PH_EXTRACT;
                            len_next   = cnt_reg - CNT_W'(1);
                            pos_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg - ADDR_W'(1);
                            pos_next = idx_reg - ADDR_W'(1);
                        end
                    end
                    else if (len_reg == CNT_W'(1))
                    begin
                        state_next = S_OREAD;
                    end
                    else
                    begin
                        len_next = len_reg - CNT_W'(1);
                        pos_next = '0;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    raddr_a    = lft[ADDR_W-1:0];
                    raddr_b    = rgt[ADDR_W-1:0];
                    state_next = S_SCMPL;
                end
            end

            // left child against the moving value
            S_SCMPL:
            begin
                cmp_a = rd_a_reg;
                cmp_b = cur_reg;
                if (cmp_win)
                begin
                    best_next  = rd_a_reg;
                    bleft_next = 1'b1;
                end
                else
                begin
                    best_next  = cur_reg;
                    bleft_next = 1'b0;
                end
                state_next = S_SCMPR;
            end

            // right child against the best so far, then move down or stop
            S_SCMPR:
            begin
                cmp_a  = rd_b_reg;
                cmp_b  = best_reg;
                mem_we = 1'b1;
                if ((rgt < CHILD_W'(len_reg)) && cmp_win)
                begin
                    mem_wdata  = rd_b_reg;
                    pos_next   = rgt[ADDR_W-1:0];
                    state_next = S_SREAD;
                end
                else if (bleft_reg)
                begin
                    mem_wdata  = best_reg;
                    pos_next   = lft[ADDR_W-1:0];
                    state_next = S_SREAD;
                end
                else
                begin
                    state_next = S_FETCH;
                    if (phase_reg == PH_BUILD)
                    begin
                        if (idx_reg == '0)
                        begin
                            phase_next = PH_EXTRACT;
                            len_next   = cnt_reg - CNT_W'(1);
                            pos_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg - ADDR_W'(1);
                            pos_next = idx_reg - ADDR_W'(1);
                        end
                    end
                    else if (len_reg == CNT_W'(1))
                    begin
                        state_next = S_OREAD;
                    end
                    else
                    begin
                        len_next = len_reg - CNT_W'(1);
                        pos_next = '0;
                    end
                end
            end

            // read the next sorted value
            S_OREAD:
            begin
                mem_re     = 1'b1;
                raddr_a    = outk_reg;
                state_next = S_OEMIT;
            end

            // present one result transaction
            S_OEMIT:
            begin
                if (out_last)
                begin
                    cnt_next     = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    outk_next  = outk_reg + ADDR_W'(1);
                    state_next = S_OREAD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            desc_reg    <= 1'b0;
            phase_reg   <= PH_BUILD;
            idx_reg     <= '0;
            len_reg     <= '0;
            pos_reg     <= '0;
            outk_reg    <= '0;
            bleft_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            desc_reg    <= desc_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            outk_reg    <= outk_next;
            bleft_reg   <= bleft_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        best_reg <= best_next;
    end

    // store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ design/hsud_checker.sv @@
`default_nettype none
`include "heap_sorter_up_down_core_defines.svh"

module hsud_checker
    import hsud_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic signed [31:0] value,
    input wire logic              final_item,
    input wire logic              cfg_wr_en,
    input wire logic              cfg_wr_data,
    input wire logic              result_valid,
    input wire logic signed [31:0] sorted_value,
    input wire logic              last_out,
    input wire logic              overflow
);

    logic load_only;

    assign load_only = start && !busy && !final_item;

    // results only come while the sort holds the block
    `HSUD_ASSERT_IMP(a_result_in_busy, clk, rst_n, result_valid, busy, "result while not busy")
    // last marker only on a result transaction
    `HSUD_ASSERT_IMP(a_last_with_valid, clk, rst_n, last_out, result_valid, "stray last_out")
    // the final result ends the run
    `HSUD_ASSERT_NXT(a_idle_after_last, clk, rst_n, result_valid && last_out, !busy,
                     "busy after last result")
    // a non-final value is only stored
    `HSUD_ASSERT_NXT(a_load_no_busy, clk, rst_n, load_only, !busy && !result_valid,
                     "non-final value started work")

endmodule

bind heap_sorter_up_down_core hsud_checker u_hsud_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsud_pkg::*;

    // one expected sorted output
    typedef struct packed {
        data_t value;
        logic  last;
        logic  ovf;
    } sorted_entry_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    data_t value;
    logic  final_item;
    logic  cfg_wr_en;
    logic  cfg_wr_data;
    logic  result_valid;
    data_t sorted_value;
    logic  last_out;
    logic  overflow;

    // predictor state: values loaded so far, drop flag, sort direction
    data_t         load_set[$];
    logic          drop_seen;
    logic          desc_mode;
    sorted_entry_t sorted_q[$];
    sorted_entry_t head;

    int gap_pct;
    int err_count;
    int items_in;
    int results_out;
    int sets_asc;
    int sets_desc;
    int overflow_sets;
    data_t last_value;

    heap_sorter_up_down_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .final_item   (final_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    // true when a belongs ahead of b in the output order
    function automatic logic goes_first(input data_t a, input data_t b, input logic desc);
        goes_first = desc ? (a > b) : (a < b);
    endfunction

    // sort the loaded set and queue its expected outputs
    task automatic emit_sorted_set();
        data_t         arr[MAX_ITEMS];
        data_t         key;
        sorted_entry_t e;
        int            n;
        int            i;
        int            j;
        n = load_set.size();
        for (i = 0; i < n; i++)
            arr[i] = load_set[i];
        for (i = 1; i < n; i++)
        begin
            key = arr[i];
            j = i - 1;
            while (j >= 0 && goes_first(key, arr[j], desc_mode))
            begin
                arr[j + 1] = arr[j];
                j--;
            end
            arr[j + 1] = key;
        end
        for (i = 0; i < n; i++)
        begin
            e.value = arr[i];
            e.last  = (i == n - 1);
            e.ovf   = drop_seen;
            sorted_q.push_back(e);
        end
        if (desc_mode)
            sets_desc++;
        else
            sets_asc++;
        if (drop_seen)
            overflow_sets++;
        load_set.delete();
        drop_seen = 1'b0;
    endtask

    // update the predictor for one accepted transaction
    task automatic load_accepted(input data_t v, input logic fin);
        if (load_set.size() < MAX_ITEMS)
            load_set.push_back(v);
        else
            drop_seen = 1'b1;
        items_in++;
        if (fin)
            emit_sorted_set();
    endtask

    // drive one value, wait for the transaction, then idle cycle by cycle
    task automatic send_value(input data_t v, input logic fin);
        start      <= 1'b1;
        value      <= v;
        final_item <= fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        load_accepted(v, fin);
        last_value = v;
        while ($urandom_range(99) < gap_pct)
        begin
            start      <= 1'b0;
            value      <= data_t'($urandom);
            final_item <= 1'($urandom);
            @(posedge clk);
        end
    endtask

    // stop sending and wait until every expected output has come
    task automatic wait_idle();
        start <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write the sort direction register
    task automatic write_order(input logic desc);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        @(posedge clk);
        desc_mode = desc;
        cfg_wr_en <= 1'b0;
    endtask

    // mix of full-range, small, extreme and repeated values
    function automatic data_t rand_value();
        case ($urandom_range(3))
            0: rand_value = data_t'(int'($urandom_range(16)) - 8);
            1:
            begin
                case ($urandom_range(3))
                    0: rand_value = 32'sh7fffffff;
                    1: rand_value = 32'sh80000000;
                    2: rand_value = 32'sd0;
                    default: rand_value = -32'sd1;
                endcase
            end
            2: rand_value = last_value;
            default: rand_value = data_t'($urandom);
        endcase
    endfunction

    task automatic send_random_set(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_value(rand_value(), k == len - 1);
    endtask

    // extremes, single value, both directions, equal values
    task automatic test_directed_sets();
        data_t pattern[7];
        int    k;
        pattern = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1,
                    32'sh55555555, 32'shaaaaaaaa};
        gap_pct = 0;
        // reset direction is ascending
        for (k = 0; k < 7; k++)
            send_value(pattern[k], k == 6);
        send_value(32'sh80000000, 1'b1);
        wait_idle();
        write_order(1'b1);
        for (k = 0; k < 7; k++)
            send_value(pattern[k], k == 6);
        send_value(32'sd7, 1'b0);
        send_value(32'sd7, 1'b0);
        send_value(-32'sd7, 1'b0);
        send_value(32'sd7, 1'b1);
        wait_idle();
    endtask

    // full store without loss, then values dropped including the final one
    task automatic test_store_capacity();
        gap_pct = 10;
        write_order(1'b0);
        send_random_set(MAX_ITEMS);
        wait_idle();
        write_order(1'b1);
        send_random_set(MAX_ITEMS + 2);
        wait_idle();
    endtask

    // random sets with the given sender idle rate
    task automatic test_random_traffic(input int idle_pct, input int quota);
        int first_item;
        int len;
        gap_pct = idle_pct;
        wait_idle();
        write_order(1'($urandom));
        first_item = items_in;
        while (items_in - first_item < quota)
        begin
            if ($urandom_range(3) == 0)
            begin
                wait_idle();
                write_order(1'($urandom));
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(20, MAX_ITEMS + 4)
                                           : $urandom_range(1, 8);
            send_random_set(len);
        end
        wait_idle();
    endtask

    // compare each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (sorted_q.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
                       sorted_value, last_out, overflow);
                err_count++;
            end
            else
            begin
                head = sorted_q.pop_front();
                results_out++;
                if (sorted_value !== head.value)
                begin
                    $error("sorted_value: expected %0d, got %0d", head.value, sorted_value);
                    err_count++;
                end
                if (last_out !== head.last)
                begin
                    $error("last_out: expected %0b, got %0b", head.last, last_out);
                    err_count++;
                end
                if (overflow !== head.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", head.ovf, overflow);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #3ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        value       <= '0;
        final_item  <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        drop_seen     = 1'b0;
        desc_mode     = 1'b0;
        gap_pct       = 0;
        err_count     = 0;
        items_in      = 0;
        results_out   = 0;
        sets_asc      = 0;
        sets_desc     = 0;
        overflow_sets = 0;
        last_value    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_sets();
        test_store_capacity();
        test_random_traffic(37, 58);
        test_random_traffic(82, 58);
        test_random_traffic(0, 58);

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d sets (%0d ascending, %0d descending), %0d with dropped values",
                 sets_asc + sets_desc, sets_asc, sets_desc, overflow_sets);
        $display("loaded %0d values, checked %0d sorted outputs, %0d mismatches",
                 items_in, results_out, err_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ heap_sorter_up_down_core.f @@
+incdir+design
design/hsud_pkg.sv
design/heap_sorter_up_down_core.sv
design/hsud_checker.sv
sim/tb.sv
